// ===== rtl/assert_macros.svh =====
// assertion macros shared by the one-shot modifier engine rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define OSMK_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("osmk assertion failed");

// next-cycle implication, checked outside reset
`define OSMK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("osmk assertion failed");

`endif

// ===== rtl/osmk_pkg.sv =====
// types and constants of the one-shot modifier key engine
package osmk_pkg;

    // modifier slots in use, at most MOD_SLOTS
    localparam int NUM_MODS = 8;
    // physical slots carried by the registers and the armed mask
    localparam int MOD_SLOTS = 8;

    localparam int KEY_W  = 11;
    localparam int CODE_W = 8;

    localparam logic [KEY_W-1:0] CODE_OFFSET = KEY_W'(1000);

    // register indexes of the configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPS_CODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODS_HIGH = 2'd2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CODE_W-1:0]     CAPS_CODE_RESET = 8'd66;
    localparam logic [CFG_DATA_W-1:0] MODS_LOW_RESET  = 32'd1764048434;
    localparam logic [CFG_DATA_W-1:0] MODS_HIGH_RESET = 32'd2256890944;

    // job queue between front and back
    localparam int JOB_FIFO_DEPTH = 2;

    typedef logic [MOD_SLOTS-1:0] t_mask;

    // configuration as seen by front and back
    typedef struct packed {
        logic [CODE_W-1:0]                  caps_code;
        logic [MOD_SLOTS-1:0][CODE_W-1:0]   slot_code;
    } t_cfg;

    typedef enum logic [1:0] {
        JOB_DOWN,   // one press event
        JOB_UP,     // one release event
        JOB_CAPS,   // press then release
        JOB_SWEEP   // release of key, then armed modifiers in code order
    } t_job_kind;

    // one classified input, as handed to the back end
    typedef struct packed {
        t_job_kind          kind;
        logic [KEY_W-1:0]   code;
        t_mask              pend;
        logic               caps;
        t_mask              armed;
    } t_job;

endpackage

// ===== rtl/osmk_in_if.sv =====
// input channel: key press and release events
interface osmk_in_if import osmk_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             command;
    logic [KEY_W-1:0] encoded_key;

    modport source (output valid, command, encoded_key, input ready);
    modport sink   (input valid, command, encoded_key, output ready);
endinterface

// ===== rtl/osmk_out_if.sv =====
// output channel: physical key events
interface osmk_out_if import osmk_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key_code;
    logic             key_down;
    logic             caps_state;
    t_mask            armed_mask;
    logic             last;

    modport source (output valid, key_code, key_down, caps_state, armed_mask, last,
                    input ready);
    modport sink   (input valid, key_code, key_down, caps_state, armed_mask, last,
                    output ready);
endinterface

// ===== rtl/osmk_front.sv =====
// front end: accepts key events, keeps modifier state, queues jobs
module osmk_front import osmk_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    osmk_in_if.sink   i_in,
    input  t_cfg      i_cfg,
    input  logic      i_full,
    output logic      o_push,
    output t_job      o_job
);

    t_mask r_held, r_used, r_armed;
    logic  r_caps;
    t_mask n_held, n_used, n_armed;
    logic  n_caps;

    logic             accept;
    logic [KEY_W-1:0] real_code;
    t_mask            match;
    t_mask            hit_bit;
    logic             mod_hit;
    logic             is_caps;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;

    // strip the code offset
    assign real_code = (i_in.encoded_key > CODE_OFFSET) ?
                       i_in.encoded_key - CODE_OFFSET : i_in.encoded_key;

    // slot lookup, lowest matching slot wins
    always_comb begin
        match = '0;
        for (int s = 0; s < NUM_MODS; s++) begin
            match[s] = (i_cfg.slot_code[s] != '0) &&
                       (real_code == {{(KEY_W-CODE_W){1'b0}}, i_cfg.slot_code[s]});
        end
    end
    assign hit_bit = match & (~match + t_mask'(1));
    assign mod_hit = |match;
    assign is_caps = (real_code == {{(KEY_W-CODE_W){1'b0}}, i_cfg.caps_code});

    // classify and update state
    always_comb begin
        n_held     = r_held;
        n_used     = r_used;
        n_armed    = r_armed;
        n_caps     = r_caps;
        o_push     = 1'b0;
        o_job.kind = JOB_DOWN;
        o_job.code = real_code;
        o_job.pend = '0;
        if (mod_hit) begin
            if (!i_in.command) begin
                o_push = ((r_armed | r_held) & hit_bit) == '0;
                n_held = r_held | hit_bit;
            end else begin
                n_held = r_held & ~hit_bit;
                n_used = r_used & ~hit_bit;
                if (((r_used | r_armed) & hit_bit) != '0) begin
                    n_armed    = r_armed & ~hit_bit;
                    o_push     = 1'b1;
                    o_job.kind = JOB_UP;
                end else begin
                    n_armed = r_armed | hit_bit;
                end
            end
        end else if (is_caps) begin
            if (i_in.command) begin
                o_push     = 1'b1;
                o_job.kind = JOB_CAPS;
                n_caps     = !r_caps;
            end
        end else if (!i_in.command) begin
            n_used = r_used | r_held;
            o_push = 1'b1;
        end else begin
            o_push     = 1'b1;
            o_job.kind = JOB_SWEEP;
            o_job.pend = r_armed & ~r_held;
            n_armed    = r_armed & r_held;
        end
        o_push      = o_push && accept;
        o_job.caps  = n_caps;
        o_job.armed = n_armed;
    end

    // modifier state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_used  <= '0;
            r_armed <= '0;
            r_caps  <= 1'b0;
        end else if (accept) begin
            r_held  <= n_held;
            r_used  <= n_used;
            r_armed <= n_armed;
            r_caps  <= n_caps;
        end
    end

`include "assert_macros.svh"

    // a chord mark only exists on a held modifier
    `OSMK_ASSERT_IMPL(a_used_held, i_clk, i_rst_n, 1'b1, (r_used & ~r_held) == '0)

endmodule

// ===== rtl/osmk_job_fifo.sv =====
// short job queue between front and back end
module osmk_job_fifo import osmk_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    localparam int PTR_W = (JOB_FIFO_DEPTH > 1) ? $clog2(JOB_FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(JOB_FIFO_DEPTH + 1);

    t_job             r_mem [JOB_FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(JOB_FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(JOB_FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(JOB_FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

`include "assert_macros.svh"

    // the front must hold off while the queue is full, the back while empty
    `OSMK_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    `OSMK_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty)

endmodule

// ===== rtl/osmk_back.sv =====
// back end: expands queued jobs into physical key events
module osmk_back import osmk_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  t_job       i_job,
    input  logic       i_empty,
    output logic       o_pop,
    osmk_out_if.source o_out
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIRST,
        ST_SECOND,
        ST_SWEEP
    } t_state;

    t_state           r_state, n_state;
    t_job             r_job, n_job;
    logic             r_out_valid, n_out_valid;
    logic [KEY_W-1:0] r_out_code, n_out_code;
    logic             r_out_down, n_out_down;
    logic             r_out_last, n_out_last;
    logic             r_out_caps, n_out_caps;
    t_mask            r_out_armed, n_out_armed;

    logic             out_free;
    logic             emit;
    logic [KEY_W-1:0] ev_code;
    logic             ev_down;
    logic             ev_last;
    logic             found;
    logic [CODE_W-1:0] best_code;
    t_mask            best_bit;
    t_mask            pend_rest;

    assign out_free = !r_out_valid || o_out.ready;
    assign emit     = out_free && (r_state != ST_IDLE);
    assign o_pop    = (r_state == ST_IDLE) && !i_empty;

    // lowest-code pending modifier, ties to the lower slot
    always_comb begin
        found     = 1'b0;
        best_code = '0;
        best_bit  = '0;
        for (int s = 0; s < NUM_MODS; s++) begin
            if (r_job.pend[s] && (!found || i_cfg.slot_code[s] < best_code)) begin
                found     = 1'b1;
                best_code = i_cfg.slot_code[s];
                best_bit  = t_mask'(1) << s;
            end
        end
        pend_rest = r_job.pend & ~best_bit;
    end

    // event of the current step and next state
    always_comb begin
        ev_code = r_job.code;
        ev_down = 1'b0;
        ev_last = 1'b1;
        n_state = r_state;
        n_job   = r_job;
        unique case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    n_job   = i_job;
                    n_state = ST_FIRST;
                end
            end
            ST_FIRST: begin
                ev_down = (r_job.kind == JOB_DOWN) || (r_job.kind == JOB_CAPS);
                ev_last = (r_job.kind == JOB_DOWN) || (r_job.kind == JOB_UP) ||
                          ((r_job.kind == JOB_SWEEP) && (r_job.pend == '0));
                if (emit) begin
                    if (ev_last) begin
                        n_state = ST_IDLE;
                    end else if (r_job.kind == JOB_CAPS) begin
                        n_state = ST_SECOND;
                    end else begin
                        n_state = ST_SWEEP;
                    end
                end
            end
            ST_SECOND: begin
                if (emit) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SWEEP: begin
                ev_code = {{(KEY_W-CODE_W){1'b0}}, best_code};
                ev_last = (pend_rest == '0);
                if (emit) begin
                    n_job.pend = pend_rest;
                    if (ev_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output register, status fields travel with the event
    always_comb begin
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_code  = r_out_code;
        n_out_down  = r_out_down;
        n_out_last  = r_out_last;
        n_out_caps  = r_out_caps;
        n_out_armed = r_out_armed;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out_code  = ev_code;
            n_out_down  = ev_down;
            n_out_last  = ev_last;
            n_out_caps  = r_job.caps;
            n_out_armed = r_job.armed;
        end
    end

    // state, job and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_job       <= n_job;
        r_out_code  <= n_out_code;
        r_out_down  <= n_out_down;
        r_out_last  <= n_out_last;
        r_out_caps  <= n_out_caps;
        r_out_armed <= n_out_armed;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.key_code   = r_out_code;
    assign o_out.key_down   = r_out_down;
    assign o_out.caps_state = r_out_caps;
    assign o_out.armed_mask = r_out_armed;
    assign o_out.last       = r_out_last;

`include "assert_macros.svh"

    // a sweep step always has a modifier left to lift
    `OSMK_ASSERT_IMPL(a_sweep_pend, i_clk, i_rst_n, r_state == ST_SWEEP, r_job.pend != '0)
    // the second event only follows a caps job
    `OSMK_ASSERT_IMPL(a_second_caps, i_clk, i_rst_n, r_state == ST_SECOND,
                      r_job.kind == JOB_CAPS)

endmodule

// ===== rtl/one_shot_modifier_key_engine.sv =====
// top level of the one-shot modifier key engine
//
//  channel  | dir | transfer                                  | handshake
//  ---------+-----+-------------------------------------------+----------------
//  i_in     | in  | command, encoded_key                      | valid / ready
//  o_out    | out | key_code, key_down, caps_state, armed_mask, last | valid / ready
//  i_cfg_*  | in  | register index, write data                | write enable
//
// an input is taken whenever the two-entry job queue has room
// the back end loads a job in its idle state, then gives one event per cycle while the
// output is not stalled; it takes the next job only once the current one's last event is out
// reset is synchronous, no clearing pass
// a stalled output holds its event; the front keeps accepting until the queue fills
module one_shot_modifier_key_engine import osmk_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    osmk_in_if.sink               i_in,
    osmk_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CODE_W-1:0]     r_caps_code;
    logic [CFG_DATA_W-1:0] r_mods_low;
    logic [CFG_DATA_W-1:0] r_mods_high;
    t_cfg                  cfg;

    logic push, pop, full, empty;
    t_job push_job, head_job;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caps_code <= CAPS_CODE_RESET;
            r_mods_low  <= MODS_LOW_RESET;
            r_mods_high <= MODS_HIGH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CAPS_CODE: r_caps_code <= i_cfg_data[CODE_W-1:0];
                CFG_MODS_LOW:  r_mods_low  <= i_cfg_data;
                CFG_MODS_HIGH: r_mods_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.caps_code = r_caps_code;
    assign cfg.slot_code = {r_mods_high, r_mods_low};

    osmk_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (cfg),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    osmk_job_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_full  (full),
        .o_empty (empty)
    );

    osmk_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_job   (head_job),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench of the one-shot modifier key engine
module testbench import osmk_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD       = 10;
    localparam int RESET_CYCLES     = 6;
    // the longest job is a nine-event release, two jobs can wait in front
    localparam int SETTLE_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int LONG_HOLD_AFTER  = 150;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int MAX_REAL_CODE    = 1047;

    localparam logic CMD_PRESS   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef struct packed {
        logic             command;
        logic [KEY_W-1:0] encoded_key;
    } t_key_stroke;

    typedef struct packed {
        logic [KEY_W-1:0] key_code;
        logic             key_down;
        logic             caps_state;
        t_mask            armed_mask;
        logic             last;
    } t_key_event;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    osmk_in_if  key_in_if ();
    osmk_out_if key_out_if ();

    one_shot_modifier_key_engine u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (key_in_if),
        .o_out      (key_out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // key map and modifier state as the block should hold them
    logic [CODE_W-1:0] caps_key = CAPS_CODE_RESET;
    logic [CODE_W-1:0] mod_code [MOD_SLOTS];
    t_mask             mod_held  = '0;
    t_mask             mod_used  = '0;
    t_mask             mod_armed = '0;
    logic              caps_on   = 1'b0;

    t_key_stroke pending_strokes [$];
    t_key_event  key_events_q [$];

    int  err_count      = 0;
    int  events_seen    = 0;
    int  send_gap       = 0;
    int  recv_hold      = 0;
    int  idle_cycles    = 0;
    bit  long_hold_done = 1'b0;
    bit  quiet_mode     = 1'b0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        err_count++;
    endtask

    // key events caused by one transfer, updates the modifier state
    task automatic predict_key_events(input logic rel, input logic [KEY_W-1:0] enc);
        logic [KEY_W-1:0] real_code;
        t_key_event       new_events [$];
        t_key_event       ev;
        int               slot;
        int               best_slot;
        int               s;
        t_mask            slot_bit;
        t_mask            sweep_mask;
        logic             was_used;

        real_code = (enc > CODE_OFFSET) ? enc - CODE_OFFSET : enc;
        slot = -1;
        if (real_code != '0) begin
            for (s = 0; s < NUM_MODS; s++) begin
                if (slot < 0 && real_code == KEY_W'(mod_code[s]))
                    slot = s;
            end
        end
        ev = '0;

        if (slot >= 0) begin
            slot_bit = t_mask'(1) << slot;
            if (rel == CMD_PRESS) begin
                if (((mod_armed | mod_held) & slot_bit) == '0) begin
                    ev.key_code = real_code;
                    ev.key_down = 1'b1;
                    new_events.push_back(ev);
                end
                mod_held |= slot_bit;
            end else begin
                was_used = (mod_used & slot_bit) != '0;
                mod_held &= ~slot_bit;
                mod_used &= ~slot_bit;
                if (was_used || (mod_armed & slot_bit) != '0) begin
                    mod_armed &= ~slot_bit;
                    ev.key_code = real_code;
                    ev.key_down = 1'b0;
                    new_events.push_back(ev);
                end else begin
                    mod_armed |= slot_bit;
                end
            end
        end else if (real_code == KEY_W'(caps_key)) begin
            // caps lock acts on release only: a full tap, then the flag flips
            if (rel == CMD_RELEASE) begin
                ev.key_code = real_code;
                ev.key_down = 1'b1;
                new_events.push_back(ev);
                ev.key_down = 1'b0;
                new_events.push_back(ev);
                caps_on = ~caps_on;
            end
        end else if (rel == CMD_PRESS) begin
            mod_used |= mod_held;
            ev.key_code = real_code;
            ev.key_down = 1'b1;
            new_events.push_back(ev);
        end else begin
            ev.key_code = real_code;
            ev.key_down = 1'b0;
            new_events.push_back(ev);
            // lift armed, released modifiers by ascending code, ties to the lower slot
            sweep_mask = mod_armed & ~mod_held;
            while (sweep_mask != '0) begin
                best_slot = -1;
                for (s = 0; s < MOD_SLOTS; s++) begin
                    if (sweep_mask[s] && (best_slot < 0 || mod_code[s] < mod_code[best_slot]))
                        best_slot = s;
                end
                ev.key_code = KEY_W'(mod_code[best_slot]);
                ev.key_down = 1'b0;
                new_events.push_back(ev);
                sweep_mask[best_slot] = 1'b0;
                mod_armed[best_slot]  = 1'b0;
            end
        end

        // status fields reflect the state after the whole transfer
        foreach (new_events[i]) begin
            new_events[i].caps_state = caps_on;
            new_events[i].armed_mask = mod_armed;
            new_events[i].last       = (i == new_events.size() - 1);
            key_events_q.push_back(new_events[i]);
        end
    endtask

    task automatic push_stroke(input logic cmd, input logic [KEY_W-1:0] enc);
        pending_strokes.push_back('{command: cmd, encoded_key: enc});
    endtask

    // half of the codes that allow it go out in the offset form
    function automatic logic [KEY_W-1:0] encode_key(input logic [KEY_W-1:0] code);
        if (code != '0 && code <= MAX_REAL_CODE && $urandom_range(0, 1) == 1)
            return code + CODE_OFFSET;
        return code;
    endfunction

    function automatic logic [KEY_W-1:0] pick_modifier();
        logic [CODE_W-1:0] code;
        code = mod_code[$urandom_range(0, MOD_SLOTS - 1)];
        if (code == '0)
            code = CODE_W'($urandom_range(1, 255));
        return KEY_W'(code);
    endfunction

    function automatic logic [KEY_W-1:0] pick_plain_key();
        return KEY_W'($urandom_range(1, MAX_REAL_CODE));
    endfunction

    // mostly well-formed taps, chords and strokes, some noise
    task automatic queue_random_strokes(input int count);
        logic [KEY_W-1:0] chord_mods [3];
        logic [KEY_W-1:0] code;
        int               added;
        int               kind;
        int               nmods;
        int               j;

        added = 0;
        while (added < count) begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                code = pick_modifier();
                push_stroke(CMD_PRESS, encode_key(code));
                push_stroke(CMD_RELEASE, encode_key(code));
                added += 2;
            end else if (kind < 55) begin
                nmods = $urandom_range(1, 3);
                for (j = 0; j < nmods; j++) begin
                    chord_mods[j] = pick_modifier();
                    push_stroke(CMD_PRESS, encode_key(chord_mods[j]));
                end
                code = pick_plain_key();
                push_stroke(CMD_PRESS, encode_key(code));
                push_stroke(CMD_RELEASE, encode_key(code));
                for (j = nmods - 1; j >= 0; j--)
                    push_stroke(CMD_RELEASE, encode_key(chord_mods[j]));
                added += 2 * nmods + 2;
            end else if (kind < 70) begin
                code = pick_plain_key();
                push_stroke(CMD_PRESS, encode_key(code));
                push_stroke(CMD_RELEASE, encode_key(code));
                added += 2;
            end else if (kind < 80) begin
                push_stroke(CMD_PRESS, encode_key(KEY_W'(caps_key)));
                push_stroke(CMD_RELEASE, encode_key(KEY_W'(caps_key)));
                added += 2;
            end else if (kind < 88) begin
                // several one-shot taps, then a stroke that sweeps them
                nmods = $urandom_range(1, MOD_SLOTS);
                for (j = 0; j < nmods; j++) begin
                    code = pick_modifier();
                    push_stroke(CMD_PRESS, encode_key(code));
                    push_stroke(CMD_RELEASE, encode_key(code));
                end
                code = pick_plain_key();
                push_stroke(CMD_PRESS, encode_key(code));
                push_stroke(CMD_RELEASE, encode_key(code));
                added += 2 * nmods + 2;
            end else begin
                push_stroke(logic'($urandom_range(0, 1)), KEY_W'($urandom_range(0, 2047)));
                added++;
            end
        end
    endtask

    // write all three registers back to back, block must be idle
    task automatic load_key_map(input logic [CODE_W-1:0] caps,
                                input logic [CFG_DATA_W-1:0] codes_lo,
                                input logic [CFG_DATA_W-1:0] codes_hi);
        int s;
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_CAPS_CODE;
        i_cfg_data <= CFG_DATA_W'(caps);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MODS_LOW;
        i_cfg_data <= codes_lo;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MODS_HIGH;
        i_cfg_data <= codes_hi;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        caps_key = caps;
        for (s = 0; s < 4; s++) begin
            mod_code[s]     = codes_lo[8 * s +: 8];
            mod_code[s + 4] = codes_hi[8 * s +: 8];
        end
        @(negedge i_clk);
    endtask

    // wait until every stroke is taken and every event has come out
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending_strokes.size() != 0 || key_in_if.valid || key_events_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_code_word();
        logic [CFG_DATA_W-1:0] word;
        int                    b;
        // small pool so that shared codes and unused slots show up
        for (b = 0; b < 4; b++)
            word[8 * b +: 8] = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 40));
        return word;
    endfunction

    // stroke driver
    always @(posedge i_clk) begin : drive_strokes
        t_key_stroke stroke;
        if (!i_rst_n) begin
            key_in_if.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (key_in_if.valid && key_in_if.ready)
                predict_key_events(key_in_if.command, key_in_if.encoded_key);
            if (!key_in_if.valid || key_in_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    key_in_if.valid <= 1'b0;
                end else if (pending_strokes.size() > 0) begin
                    stroke = pending_strokes.pop_front();
                    key_in_if.valid       <= 1'b1;
                    key_in_if.command     <= stroke.command;
                    key_in_if.encoded_key <= stroke.encoded_key;
                    if (!quiet_mode && $urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 19);
                end else begin
                    key_in_if.valid <= 1'b0;
                end
            end
        end
    end

    // event monitor and receiver stalls
    always @(posedge i_clk) begin : watch_events
        t_key_event want;
        if (!i_rst_n) begin
            key_out_if.ready <= 1'b0;
            recv_hold = 0;
        end else begin
            if (key_out_if.valid && key_out_if.ready) begin
                events_seen++;
                if (key_events_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected event code %0d down %0b",
                                              key_out_if.key_code, key_out_if.key_down));
                end else begin
                    want = key_events_q.pop_front();
                    if (key_out_if.key_code !== want.key_code)
                        report_mismatch($sformatf("key_code got %0d want %0d",
                                                  key_out_if.key_code, want.key_code));
                    if (key_out_if.key_down !== want.key_down)
                        report_mismatch($sformatf("key_down got %b want %b",
                                                  key_out_if.key_down, want.key_down));
                    if (key_out_if.caps_state !== want.caps_state)
                        report_mismatch($sformatf("caps_state got %b want %b",
                                                  key_out_if.caps_state, want.caps_state));
                    if (key_out_if.armed_mask !== want.armed_mask)
                        report_mismatch($sformatf("armed_mask got %b want %b",
                                                  key_out_if.armed_mask, want.armed_mask));
                    if (key_out_if.last !== want.last)
                        report_mismatch($sformatf("last got %b want %b",
                                                  key_out_if.last, want.last));
                end
            end
            // one long hold while strokes keep coming, so the job queue fills
            if (recv_hold > 0) begin
                recv_hold--;
                key_out_if.ready <= 1'b0;
            end else if (!long_hold_done && events_seen >= LONG_HOLD_AFTER) begin
                long_hold_done = 1'b1;
                recv_hold = LONG_HOLD_CYCLES;
                key_out_if.ready <= 1'b0;
            end else if (!quiet_mode && $urandom_range(0, 11) == 0) begin
                recv_hold = $urandom_range(0, 18);
                key_out_if.ready <= 1'b0;
            end else begin
                key_out_if.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((key_in_if.valid && key_in_if.ready) || (key_out_if.valid && key_out_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    // reset, key maps and stroke phases
    initial begin
        int s;
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = CFG_CAPS_CODE;
        i_cfg_data            = '0;
        key_in_if.valid       = 1'b0;
        key_in_if.command     = CMD_PRESS;
        key_in_if.encoded_key = '0;
        key_out_if.ready      = 1'b0;
        for (s = 0; s < 4; s++) begin
            mod_code[s]     = MODS_LOW_RESET[8 * s +: 8];
            mod_code[s + 4] = MODS_HIGH_RESET[8 * s +: 8];
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset key map: field extremes, held, armed and chorded modifiers, caps
        push_stroke(CMD_PRESS, 11'd0);
        push_stroke(CMD_RELEASE, 11'd2047);
        push_stroke(CMD_PRESS, KEY_W'(caps_key));
        push_stroke(CMD_RELEASE, KEY_W'(caps_key) + CODE_OFFSET);
        push_stroke(CMD_PRESS, KEY_W'(mod_code[0]));
        push_stroke(CMD_PRESS, KEY_W'(mod_code[0]));
        push_stroke(CMD_RELEASE, KEY_W'(mod_code[0]));
        push_stroke(CMD_PRESS, KEY_W'(mod_code[0]));
        push_stroke(CMD_PRESS, CODE_OFFSET);
        push_stroke(CMD_RELEASE, CODE_OFFSET + 11'd1);
        push_stroke(CMD_RELEASE, KEY_W'(mod_code[0]));
        push_stroke(CMD_PRESS, KEY_W'(mod_code[1]) + CODE_OFFSET);
        push_stroke(CMD_RELEASE, KEY_W'(mod_code[1]));
        push_stroke(CMD_RELEASE, CODE_OFFSET + 11'd255);
        queue_random_strokes(90);
        wait_drained();

        // distinct codes out of slot order, caps on code zero
        load_key_map(8'd0, 32'h1E280A32, 32'hFF05143C);
        push_stroke(CMD_RELEASE, 11'd0);
        push_stroke(CMD_RELEASE, 11'd500);
        for (s = 0; s < MOD_SLOTS; s++) begin
            push_stroke(CMD_PRESS, KEY_W'(mod_code[s]));
            push_stroke(CMD_RELEASE, KEY_W'(mod_code[s]));
        end
        push_stroke(CMD_RELEASE, 11'd600);
        queue_random_strokes(100);
        wait_drained();

        // one code shared by four slots and by caps, upper slots unused
        load_key_map(8'hFF, 32'hFFFFFFFF, 32'h00000000);
        queue_random_strokes(100);
        wait_drained();

        load_key_map(8'($urandom_range(0, 255)), random_code_word(), random_code_word());
        queue_random_strokes(100);
        wait_drained();

        // last phase runs back to back on both sides
        quiet_mode = 1'b1;
        load_key_map(CAPS_CODE_RESET, MODS_LOW_RESET, MODS_HIGH_RESET);
        queue_random_strokes(100);
        wait_drained();

        if (err_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/osmk_pkg.sv
rtl/osmk_in_if.sv
rtl/osmk_out_if.sv
rtl/osmk_front.sv
rtl/osmk_job_fifo.sv
rtl/osmk_back.sv
rtl/one_shot_modifier_key_engine.sv
tb/sv/testbench.sv
